// File: hdl/tspec_admission_control_assert.svh
// Assertion macros used by the checker of the TSPEC admission control block.
`ifndef TSPEC_ADMISSION_CONTROL_ASSERT_SVH
`define TSPEC_ADMISSION_CONTROL_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define TAC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define TAC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/tac_pkg.sv
// Types and constants of the TSPEC admission control block.
`timescale 1ns / 1ps

package tac_pkg;

  // Result status codes.
  localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
  localparam logic [1:0] STATUS_INVALID  = 2'd1;
  localparam logic [1:0] STATUS_REFUSED  = 2'd2;
  localparam logic [1:0] STATUS_RELEASED = 2'd3;

  // Operation codes of an input transaction.
  localparam logic OP_ADMIT   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Register map.
  localparam logic [1:0]  ADDR_BUDGET  = 2'd0;
  localparam logic [31:0] BUDGET_RESET = 32'd1000000;

  // Arithmetic constants.
  localparam logic [19:0] PHY_UNIT_BPS   = 20'd1000000;
  localparam logic [15:0] SURPLUS_UNITY  = 16'h2000;
  localparam logic [18:0] FRAME_OVERHEAD = 19'd50;

  // One input transaction.
  typedef struct packed {
    logic        operation;
    logic [15:0] msdu_size_word;
    logic [31:0] mean_rate_bps;
    logic [31:0] min_phy_rate_bps;
    logic [15:0] surplus_allowance;
    logic [31:0] release_amount;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] granted_time_units;
    logic [31:0] used_airtime;
  } out_item_t;

endpackage

// File: hdl/tspec_admission_control.sv
// TSPEC admission control: bit-serial airtime estimate and admission decision.
//
// Usage: each input transaction on in_valid_i / in_stall_o is an admission
// request or a release of medium time. Every input transaction yields exactly
// one result transaction on out_valid_o / out_stall_i with a status, the
// granted time in 32 us units and the airtime in use afterwards.
// Releases and requests with invalid parameters go from acceptance straight to
// the result step. A valid request runs two restoring dividers at one quotient
// bit per cycle (packets per second and PHY rate in Mbps), then the frame
// duration division while a shift-add multiplier forms surplus * pps, then the
// shift-add product with the duration, then the budget compare. One item is in
// work at a time; the next one is accepted in the cycle after the result is
// registered.
// The output register holds a result while the receiver stalls; a finished
// item waits in its last step until that register is free.
// Reset clears the airtime in use, sets the budget to 1000000 us and empties
// the output register. The budget register is to be written over the APB port
// only while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module tspec_admission_control (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tac_pkg::in_item_t    in_data_i,
  // Output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tac_pkg::out_item_t   out_data_o,
  // Configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV1 = 3'd1;
  localparam logic [2:0] S_DIV2 = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam logic [4:0] DIV1_LAST = 5'd31;
  localparam logic [4:0] DIV2_LAST = 5'd17;
  localparam logic [4:0] MUL_LAST  = 5'd18;

  logic [2:0]  state_q;
  logic [4:0]  cnt_q;
  logic        op_q;
  logic        inval_q;
  logic [31:0] amount_q;
  logic [14:0] size_q;

  // Divider A: packets per second, then frame duration.
  logic [31:0] qa_q;
  logic [15:0] ra_q;
  logic [15:0] da_q;
  // Divider B: PHY rate in Mbps.
  logic [31:0] qb_q;
  logic [19:0] rb_q;

  // Multipliers.
  logic [29:0] pps_q;
  logic [17:0] sur_q;
  logic [45:0] acc1_q;
  logic [18:0] dur_q;
  logic [63:0] acc2_q;

  logic [31:0] in_use_q;
  logic [31:0] budget_q;
  logic        out_valid_q;
  tac_pkg::out_item_t out_q;

  logic        in_accept;
  logic        out_free;
  logic        fin_fire;
  logic        req_invalid;

  logic [16:0] ra_sh;
  logic        ge_a;
  logic [15:0] ra_d;
  logic [31:0] qa_d;
  logic [20:0] rb_sh;
  logic        ge_b;
  logic [19:0] rb_d;
  logic [31:0] qb_d;
  logic [45:0] acc1_d;
  logic [63:0] acc2_d;
  logic [18:0] dur_d;

  logic [50:0] med_time;
  logic [51:0] total;
  logic        over;
  tac_pkg::out_item_t fin_item;
  logic [31:0] in_use_d;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fin_fire   = (state_q == S_FIN) && out_free;

  // Parameter checks, in the order of the specification.
  assign req_invalid = (in_data_i.msdu_size_word == 16'd0) ||
                       (in_data_i.min_phy_rate_bps < 32'(tac_pkg::PHY_UNIT_BPS)) ||
                       (in_data_i.surplus_allowance <= tac_pkg::SURPLUS_UNITY);

  // One restoring division step on each divider.
  always_comb begin
    ra_sh = {ra_q, qa_q[31]};
    ge_a  = (ra_sh >= {1'b0, da_q});
    ra_d  = ge_a ? 16'(ra_sh - {1'b0, da_q}) : ra_sh[15:0];
    qa_d  = {qa_q[30:0], ge_a};
    rb_sh = {rb_q, qb_q[31]};
    ge_b  = (rb_sh >= {1'b0, tac_pkg::PHY_UNIT_BPS});
    rb_d  = ge_b ? 20'(rb_sh - {1'b0, tac_pkg::PHY_UNIT_BPS}) : rb_sh[19:0];
    qb_d  = {qb_q[30:0], ge_b};
  end

  // One shift-add step on each multiplier, most significant bit first.
  always_comb begin
    acc1_d = {acc1_q[44:0], 1'b0} + (sur_q[17] ? {16'd0, pps_q} : 46'd0);
    acc2_d = {acc2_q[62:0], 1'b0} + (dur_q[18] ? {18'd0, acc1_q} : 64'd0);
    dur_d  = {1'b0, qa_d[17:0]} + tac_pkg::FRAME_OVERHEAD;
  end

  // Budget check and result of the finished transaction.
  always_comb begin
    med_time = acc2_q[63:13];
    total    = {20'd0, in_use_q} + {1'b0, med_time};
    over     = (total > {20'd0, budget_q});
    in_use_d = in_use_q;
    fin_item.status             = tac_pkg::STATUS_INVALID;
    fin_item.granted_time_units = 16'd0;
    if (op_q == tac_pkg::OP_RELEASE) begin
      fin_item.status = tac_pkg::STATUS_RELEASED;
      in_use_d        = (amount_q > in_use_q) ? 32'd0 : (in_use_q - amount_q);
    end else if (inval_q) begin
      fin_item.status = tac_pkg::STATUS_INVALID;
    end else if (over) begin
      fin_item.status = tac_pkg::STATUS_REFUSED;
    end else begin
      fin_item.status             = tac_pkg::STATUS_ACCEPTED;
      fin_item.granted_time_units = acc2_q[33:18];
      in_use_d                    = total[31:0];
    end
    fin_item.used_airtime = in_use_d;
  end

  // Sequencer and control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= 5'd0;
      in_use_q    <= 32'd0;
      budget_q    <= tac_pkg::BUDGET_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        budget_q <= pwdata;
      end
      if (out_valid_q && !out_stall_i && !fin_fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            cnt_q <= DIV1_LAST;
            if ((in_data_i.operation == tac_pkg::OP_RELEASE) || req_invalid) begin
              state_q <= S_FIN;
            end else begin
              state_q <= S_DIV1;
            end
          end
        end
        S_DIV1: begin
          if (cnt_q == 5'd0) begin
            cnt_q   <= DIV2_LAST;
            state_q <= S_DIV2;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        S_DIV2: begin
          if (cnt_q == 5'd0) begin
            cnt_q   <= MUL_LAST;
            state_q <= S_MUL;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        S_MUL: begin
          if (cnt_q == 5'd0) begin
            state_q <= S_FIN;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        S_FIN: begin
          if (out_free) begin
            in_use_q    <= in_use_d;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          op_q     <= in_data_i.operation;
          inval_q  <= req_invalid;
          amount_q <= in_data_i.release_amount;
          size_q   <= in_data_i.msdu_size_word[14:0];
          // Dividend of the rounded-up packet rate: bytes per second plus divisor - 1.
          qa_q     <= {3'd0, in_data_i.mean_rate_bps[31:3]}
                      + {16'd0, in_data_i.msdu_size_word} - 32'd1;
          ra_q     <= 16'd0;
          da_q     <= in_data_i.msdu_size_word;
          qb_q     <= in_data_i.min_phy_rate_bps;
          rb_q     <= 20'd0;
          sur_q    <= {2'd0, in_data_i.surplus_allowance};
          acc1_q   <= 46'd0;
        end
      end
      S_DIV1: begin
        qb_q <= qb_d;
        rb_q <= rb_d;
        if (cnt_q == 5'd0) begin
          // Load the duration division: bits per frame over Mbps.
          pps_q <= qa_d[29:0];
          da_q  <= qb_d[15:0];
          qa_q  <= {size_q, 3'd0, 14'd0};
          ra_q  <= 16'd0;
        end else begin
          qa_q <= qa_d;
          ra_q <= ra_d;
        end
      end
      S_DIV2: begin
        qa_q   <= qa_d;
        ra_q   <= ra_d;
        acc1_q <= acc1_d;
        sur_q  <= {sur_q[16:0], 1'b0};
        if (cnt_q == 5'd0) begin
          dur_q  <= dur_d;
          acc2_q <= 64'd0;
        end
      end
      S_MUL: begin
        acc2_q <= acc2_d;
        dur_q  <= {dur_q[17:0], 1'b0};
      end
      S_FIN: begin
        if (fin_fire) begin
          out_q <= fin_item;
        end
      end
      default: begin
      end
    endcase
  end

  // Outputs and register read-back.
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr == tac_pkg::ADDR_BUDGET) ? budget_q : 32'd0;

endmodule

// File: hdl/tac_checker.sv
// Port-level checker of the TSPEC admission control block, bound to the top level.
`timescale 1ns / 1ps
`include "tspec_admission_control_assert.svh"

module tac_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input tac_pkg::out_item_t out_data_o,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [1:0]         paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata,
  input logic               pready
);

  // A stalled result transaction stays on the port unchanged.
  `TAC_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")

  // Only an accepted request grants medium time.
  `TAC_ASSERT_IMP(a_grant_zero, out_valid_o && (out_data_o.status != tac_pkg::STATUS_ACCEPTED), out_data_o.granted_time_units == 16'd0, "time granted without admission")

  // The block works on one transaction at a time.
  `TAC_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "input not stalled after acceptance")

  // A budget write reads back on the next cycle.
  `TAC_ASSERT_NXT(a_budget_readback, psel && penable && pwrite && pready, (paddr != tac_pkg::ADDR_BUDGET) || (prdata == $past(pwdata)), "budget read-back mismatch")

endmodule

bind tspec_admission_control tac_checker u_tac_checker (.*);
